[hdl/pqads_pkg.sv]
// Shared constants and types for the product-quantization distance scan.
package pqads_pkg;

   localparam int DEFAULT_MAX_SUBSPACES = 256;
   localparam int CENTROIDS             = 256;
   localparam int CENT_W                = 8;
   localparam int SUBSPACE_W            = 8;
   localparam int POSITION_W            = 8;
   localparam int VALUE_W               = 24;
   localparam int SCORE_W               = 32;
   localparam int SUM_W                 = 33;
   localparam int COUNT_W               = 9;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CODE = 1'b1;

   localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
   localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;

   // Result buffer behind the accumulator.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               saturated;
   } rsp_entry_type;

endpackage

[hdl/pqads_if.sv]
// Channel interfaces for the request, result and configuration beats.
interface pqads_req_if import pqads_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic        [SUBSPACE_W-1:0] subspace;
   logic        [CENT_W-1:0]     centroid;
   logic signed [VALUE_W-1:0]    table_value;

   modport source (output valid, command, subspace, centroid, table_value, input ready);
   modport sink   (input valid, command, subspace, centroid, table_value, output ready);
endinterface

interface pqads_rsp_if import pqads_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] score;
   logic                      saturated;

   modport source (output valid, score, saturated, input ready);
   modport sink   (input valid, score, saturated, output ready);
endinterface

interface pqads_csr_if import pqads_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/pqads_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pqads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pq_asymmetric_distance_scan_top.sv]
// Top level of the product-quantization distance scan.
//
//   channel | dir | beat content                                  | accepted when
//   --------+-----+-----------------------------------------------+-----------------------
//   req     | in  | command, subspace, centroid, table_value      | req.valid & req.ready
//   rsp     | out | score, saturated (one per completed code row) | rsp.valid & rsp.ready
//   csr     | in  | data: subspaces per row                       | csr.valid & csr.ready
//
// One request beat per cycle while ready: each needs one table RAM access, made in its accept cycle.
// A row's score passes the read stage into a four-entry result buffer, which offers it on rsp.
// Request ready drops only while the result buffer plus an in-flight row end would overfill it.
// Reset is synchronous; it clears the accumulator, position and buffer state and sets the count to 8.
// The table RAM is not cleared; an entry must be loaded before a code beat reads it.
module pq_asymmetric_distance_scan_top import pqads_pkg::*; #(
   parameter int MAX_SUBSPACES = DEFAULT_MAX_SUBSPACES
) (
   input  logic         clock,
   input  logic         reset,
   pqads_req_if.sink    req,
   pqads_rsp_if.source  rsp,
   pqads_csr_if.sink    csr
);

   localparam int TBL_DEPTH = MAX_SUBSPACES * CENTROIDS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SUBSPACES);

   // Configuration register.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_eff;

   // Row position and accumulator.
   logic [POSITION_W-1:0] position_ff, position_in;
   logic signed [SUM_W-1:0] row_sum_ff, row_sum_in;

   // Stage holding a code beat while its table entry is read.
   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff, s1_last_in;

   // Result buffer.
   rsp_entry_type          rsp_buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   occ_ff, occ_in;

   logic                   req_accept;
   logic                   load_beat;
   logic                   code_beat;
   logic                   code_last;
   logic                   load_in_range;
   logic [2*CENT_W-1:0]    wr_addr_wide;
   logic [2*CENT_W-1:0]    rd_addr_wide;
   logic [VALUE_W-1:0]     tbl_rd_data;
   logic signed [SUM_W-1:0] sum_next;
   rsp_entry_type          push_entry;
   logic                   push;
   logic                   pop;
   logic [RSP_CNT_W:0]     reserved;

   // Handshakes.
   assign reserved   = {1'b0, occ_ff} + {{RSP_CNT_W{1'b0}}, (s1_valid_ff & s1_last_ff)};
   assign req.ready  = (reserved < (RSP_CNT_W+1)'(RSP_DEPTH));
   assign csr.ready  = 1'b1;
   assign req_accept = req.valid & req.ready;
   assign load_beat  = req_accept & (req.command == CMD_LOAD);
   assign code_beat  = req_accept & (req.command == CMD_CODE);

   // A count of zero acts as one, and anything above the table height is capped.
   always_comb begin
      count_eff = count_ff;
      if (count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (count_ff > MAX_COUNT) begin
         count_eff = MAX_COUNT;
      end
   end

   assign code_last = (({1'b0, position_ff} + COUNT_W'(1)) >= count_eff);

   assign load_in_range = ({1'b0, req.subspace} < MAX_COUNT);
   assign wr_addr_wide  = {req.subspace, req.centroid};
   assign rd_addr_wide  = {position_ff, req.centroid};

   pqads_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_beat & load_in_range),
      .wr_addr (wr_addr_wide[TBL_AW-1:0]),
      .wr_data (req.table_value),
      .rd_en   (code_beat),
      .rd_addr (rd_addr_wide[TBL_AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   // Position advances at accept time; the sum follows in the next cycle with the read data.
   always_comb begin
      count_in    = count_ff;
      position_in = position_ff;
      s1_valid_in = code_beat;
      s1_last_in  = code_last;
      row_sum_in  = row_sum_ff;
      if (csr.valid & csr.ready) begin
         count_in = csr.data;
      end
      if (code_beat) begin
         position_in = code_last ? '0 : position_ff + POSITION_W'(1);
      end
      sum_next = row_sum_ff + {{(SUM_W-VALUE_W){tbl_rd_data[VALUE_W-1]}}, tbl_rd_data};
      if (s1_valid_ff) begin
         row_sum_in = s1_last_ff ? '0 : sum_next;
      end
   end

   // Clamp the finished row to the score range.
   always_comb begin
      push_entry.saturated = (sum_next[SUM_W-1] != sum_next[SCORE_W-1]);
      if (!sum_next[SUM_W-1] && sum_next[SCORE_W-1]) begin
         push_entry.score = SCORE_MAX;
      end else if (sum_next[SUM_W-1] && !sum_next[SCORE_W-1]) begin
         push_entry.score = SCORE_MIN;
      end else begin
         push_entry.score = sum_next[SCORE_W-1:0];
      end
   end

   assign push = s1_valid_ff & s1_last_ff;
   assign pop  = rsp.valid & rsp.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      occ_in    = occ_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= COUNT_RESET;
         position_ff <= '0;
         row_sum_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         occ_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         position_ff <= position_in;
         row_sum_ff  <= row_sum_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         occ_ff      <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_buf_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp.valid     = (occ_ff != '0);
   assign rsp.score     = rsp_buf_ff[rd_ptr_ff].score;
   assign rsp.saturated = rsp_buf_ff[rd_ptr_ff].saturated;

endmodule

[hdl/pqads_checker.sv]
// Port-level checks for the distance scan top level, attached by bind.
module pqads_checker import pqads_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SCORE_W-1:0] rsp_score,
   input logic               rsp_saturated
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_score) && $stable(rsp_saturated))
      else $error("stalled result payload changed");

   // An empty result side fills only from an accepted code beat, through the read stage and buffer.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_command == CMD_CODE), 2))
      else $error("result appeared without a matching code beat");

   // The request side stalls only while results are waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no result pending");

endmodule

bind pq_asymmetric_distance_scan_top pqads_checker u_pqads_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_command   (req.command),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_score     (rsp.score),
   .rsp_saturated (rsp.saturated)
);

[tb/tb_top.sv]
// Self-checking testbench for the product-quantization distance scan top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pqads_pkg::*;

   localparam int MAX_ROWS = DEFAULT_MAX_SUBSPACES;
   localparam int TAB_SIZE = MAX_ROWS * CENTROIDS;

   // Random phases: count written, sender idle percent, receiver stall percent, beats.
   localparam int PH_NUM = 6;
   localparam int PH_COUNT [PH_NUM] = '{1, 5, 0, 256, 511, 7};
   localparam int PH_IDLE  [PH_NUM] = '{0, 52, 0, 36, 0, 36};
   localparam int PH_STALL [PH_NUM] = '{0, 0, 52, 36, 0, 36};
   localparam int PH_BEATS [PH_NUM] = '{60, 60, 50, 80, 30, 60};

   localparam logic [CENT_W-1:0] DIR_CENT [8] =
      '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h7F};
   localparam logic [VALUE_W-1:0] DIR_VAL [8] =
      '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
        24'h000001, 24'h7FFFFF, 24'h800000, 24'h123456};

   // Mirrors the distance table and row accumulator and holds the row scores still due.
   class score_tracker;
      logic [COUNT_W-1:0]        count_reg;
      logic signed [SUM_W-1:0]   row_sum;
      logic [POSITION_W-1:0]     position;
      logic signed [VALUE_W-1:0] dist_tab [TAB_SIZE];
      bit                        loaded   [TAB_SIZE];
      rsp_entry_type             due_scores [$];
      int                        errors;
      int                        loads_seen;
      int                        codes_seen;
      int                        scores_seen;

      function new();
         count_reg   = COUNT_RESET;
         row_sum     = '0;
         position    = '0;
         errors      = 0;
         loads_seen  = 0;
         codes_seen  = 0;
         scores_seen = 0;
      endfunction

      function void set_count(input logic [COUNT_W-1:0] v);
         count_reg = v;
      endfunction

      // A count of zero acts as one, and anything past MAX_ROWS acts as MAX_ROWS.
      function logic [COUNT_W-1:0] row_len();
         if (count_reg == '0) return COUNT_W'(1);
         if (count_reg > COUNT_W'(MAX_ROWS)) return COUNT_W'(MAX_ROWS);
         return count_reg;
      endfunction

      function void note_request(input logic cmd, input logic [SUBSPACE_W-1:0] s,
                                 input logic [CENT_W-1:0] c,
                                 input logic signed [VALUE_W-1:0] v);
         logic signed [VALUE_W-1:0] entry;
         rsp_entry_type             e;
         if (cmd == CMD_LOAD) begin
            dist_tab[{s, c}] = v;
            loaded[{s, c}]   = 1'b1;
            loads_seen++;
            return;
         end
         codes_seen++;
         entry   = dist_tab[{position, c}];
         row_sum = row_sum + $signed({{(SUM_W-VALUE_W){entry[VALUE_W-1]}}, entry});
         if (({1'b0, position} + COUNT_W'(1)) < row_len()) begin
            position = position + 1'b1;
         end else begin
            if (row_sum > $signed({1'b0, SCORE_MAX})) begin
               e.score     = SCORE_MAX;
               e.saturated = 1'b1;
            end else if (row_sum < $signed({1'b1, SCORE_MIN})) begin
               e.score     = SCORE_MIN;
               e.saturated = 1'b1;
            end else begin
               e.score     = row_sum[SCORE_W-1:0];
               e.saturated = 1'b0;
            end
            due_scores.push_back(e);
            row_sum  = '0;
            position = '0;
         end
      endfunction

      function void check_result(input logic signed [SCORE_W-1:0] score, input logic sat);
         rsp_entry_type e;
         if (due_scores.size() == 0) begin
            $display("%0t: row score with none due, actual score=%0d saturated=%0b",
                     $time, score, sat);
            errors++;
            return;
         end
         e = due_scores.pop_front();
         scores_seen++;
         if (score !== e.score) begin
            $display("%0t: score mismatch, expected %0d actual %0d",
                     $time, $signed(e.score), score);
            errors++;
         end
         if (sat !== e.saturated) begin
            $display("%0t: saturated mismatch, expected %0b actual %0b",
                     $time, e.saturated, sat);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pqads_req_if req_if ();
   pqads_rsp_if rsp_if ();
   pqads_csr_if csr_if ();

   pq_asymmetric_distance_scan_top #(.MAX_SUBSPACES(MAX_ROWS)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   score_tracker sb;
   int req_idle_pct;
   int rsp_stall_pct;
   int hold_request;
   int csr_writes;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("** pq_asymmetric_distance_scan_top: FAILED **");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off counted here when one is requested.
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.score, rsp_if.saturated);
      end
   end

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(5))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         2:       return '0;
         3:       return VALUE_W'($urandom_range(511)) - VALUE_W'(256);
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   task automatic send_beat(input logic cmd, input logic [SUBSPACE_W-1:0] s,
                            input logic [CENT_W-1:0] c,
                            input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.subspace    <= s;
      req_if.centroid    <= c;
      req_if.table_value <= v;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(cmd, s, c, v);
   endtask

   // A code byte must hit a loaded entry of the current subspace, so load one first if needed.
   task automatic send_code_random();
      logic [POSITION_W-1:0] p;
      logic [CENT_W-1:0]     c;
      logic [CENT_W-1:0]     probe;
      p = sb.position;
      c = CENT_W'($urandom_range(255));
      if ($urandom_range(3) != 0 && !sb.loaded[{p, c}]) begin
         probe = c;
         for (int k = 0; k < CENTROIDS; k++) begin
            probe = probe + 1'b1;
            if (sb.loaded[{p, probe}]) begin
               c = probe;
               break;
            end
         end
      end
      if (!sb.loaded[{p, c}])
         send_beat(CMD_LOAD, p, c, rand_value());
      send_beat(CMD_CODE, SUBSPACE_W'($urandom_range(255)), c, rand_value());
   endtask

   task automatic random_item();
      logic [SUBSPACE_W-1:0] s;
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(2) == 0)
            s = SUBSPACE_W'($urandom_range(255));
         else
            s = SUBSPACE_W'($urandom_range(int'(sb.row_len()) - 1));
         send_beat(CMD_LOAD, s, CENT_W'($urandom_range(255)), rand_value());
      end else begin
         send_code_random();
      end
   endtask

   // Stop offering beats, let every due score arrive, then allow the pipeline to empty.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.due_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] v);
      csr_if.valid <= 1'b1;
      csr_if.data  <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.set_count(v);
      csr_writes++;
   endtask

   initial begin
      sb                 = new();
      req_idle_pct       = 0;
      rsp_stall_pct      = 0;
      hold_request       = 0;
      csr_writes         = 0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = CMD_LOAD;
      req_if.subspace    = '0;
      req_if.centroid    = '0;
      req_if.table_value = '0;
      csr_if.valid       = 1'b0;
      csr_if.data        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One row at the reset count, over extreme values and code bytes.
      for (int i = 0; i < 8; i++)
         send_beat(CMD_LOAD, SUBSPACE_W'(i), DIR_CENT[i], DIR_VAL[i]);
      for (int i = 0; i < 8; i++)
         send_beat(CMD_CODE, SUBSPACE_W'(255 - i), DIR_CENT[i], '0);

      // Shrink the count while a row is three bytes in; the next byte closes it.
      for (int i = 0; i < 3; i++)
         send_beat(CMD_CODE, '0, DIR_CENT[i], '0);
      settle();
      write_count(COUNT_W'(2));
      send_beat(CMD_CODE, '0, DIR_CENT[3], '0);

      // A zero count behaves as one byte per row.
      settle();
      write_count('0);
      send_beat(CMD_CODE, '0, DIR_CENT[0], '0);
      send_beat(CMD_CODE, 8'hFF, DIR_CENT[0], 24'hFFFFFF);

      for (int ph = 0; ph < PH_NUM; ph++) begin
         settle();
         write_count(COUNT_W'(PH_COUNT[ph]));
         req_idle_pct  = PH_IDLE[ph];
         rsp_stall_pct = PH_STALL[ph];
         for (int i = 0; i < PH_BEATS[ph]; i++) begin
            if (i == PH_BEATS[ph] / 2)
               settle();
            random_item();
         end
      end

      // Hold the result side off long enough for the buffer to fill and stall requests.
      settle();
      write_count(COUNT_W'(1));
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request  = 200;
      repeat (40) send_code_random();

      settle();
      repeat (20) @(posedge clock);
      if (sb.due_scores.size() != 0)
         $display("%0t: %0d row scores never arrived", $time, sb.due_scores.size());
      $display("Covered %0d request beats: %0d table loads, %0d code bytes, %0d row scores.",
               sb.loads_seen + sb.codes_seen, sb.loads_seen, sb.codes_seen, sb.scores_seen);
      $display("Counts from 0 to 511 over %0d writes, rows cut short, idles, stalls, a hold-off.",
               csr_writes);
      if (sb.errors == 0 && sb.due_scores.size() == 0) begin
         $display("** pq_asymmetric_distance_scan_top: PASSED **");
      end else begin
         $display("** pq_asymmetric_distance_scan_top: FAILED **");
      end
      $finish;
   end

endmodule
